/* design/wm3o6_pkg.sv */
// Shared types and constants for the mode T 3-out-of-6 telegram extractor.
`default_nettype none

package wm3o6_pkg;

  localparam int unsigned GroupW    = 24;  // one received code group
  localparam int unsigned SymW      = 6;   // one 3-of-6 symbol
  localparam int unsigned NibW      = 4;
  localparam int unsigned NumSyms   = GroupW / SymW;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 9;   // telegram length, up to 288
  localparam int unsigned LenBase   = 9;   // L field of a single block
  localparam int unsigned LenOffset = 3;   // L field byte plus first CRC
  localparam int unsigned BlockSh   = 4;   // 16 bytes per extra block
  localparam int unsigned QueueDepth = 2;

  // One lane's symbol decode.
  typedef struct packed {
    logic            ok;
    logic [NibW-1:0] nib;
  } lane_res_t;

  // Results caused by one accepted group, one or two bytes or one error.
  typedef struct packed {
    logic [ByteW-1:0] byte0;
    logic [ByteW-1:0] byte1;
    logic             last0;
    logic             last1;
    logic             err;
    logic             two;   // second byte present
  } item_t;

endpackage

`default_nettype wire

/* design/wm3o6_if.sv */
// Valid/ready channel interfaces for code groups and decoded bytes.
`default_nettype none

interface wm3o6_grp_if
  import wm3o6_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [GroupW-1:0] code_group;
  logic              packet_start;

  modport source (output valid, output code_group, output packet_start, input ready);
  modport sink   (input valid, input code_group, input packet_start, output ready);
endinterface

interface wm3o6_byte_if
  import wm3o6_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             last_flag;
  logic             symbol_error;

  modport source (output valid, output data_byte, output last_flag, output symbol_error,
                  input ready);
  modport sink   (input valid, input data_byte, input last_flag, input symbol_error,
                  output ready);
endinterface

`default_nettype wire

/* design/wm3o6_sym_lane.sv */
// One symbol lane: 3-out-of-6 code to nibble, with validity flag.
`default_nettype none

module wm3o6_sym_lane
  import wm3o6_pkg::*;
(
  input  wire logic [SymW-1:0] sym_i,
  output lane_res_t            res_o
);

  always_comb begin
    res_o.ok = 1'b1;
    unique case (sym_i)
      6'h16: res_o.nib = 4'h0;
      6'h0D: res_o.nib = 4'h1;
      6'h0E: res_o.nib = 4'h2;
      6'h0B: res_o.nib = 4'h3;
      6'h1C: res_o.nib = 4'h4;
      6'h19: res_o.nib = 4'h5;
      6'h1A: res_o.nib = 4'h6;
      6'h13: res_o.nib = 4'h7;
      6'h2C: res_o.nib = 4'h8;
      6'h25: res_o.nib = 4'h9;
      6'h26: res_o.nib = 4'hA;
      6'h23: res_o.nib = 4'hB;
      6'h34: res_o.nib = 4'hC;
      6'h31: res_o.nib = 4'hD;
      6'h32: res_o.nib = 4'hE;
      6'h29: res_o.nib = 4'hF;
      default: begin
        res_o.ok  = 1'b0;
        res_o.nib = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/wm3o6_merge.sv */
// Merges lane nibbles into bytes, tracks telegram length and packet state.
`default_nettype none

module wm3o6_merge
  import wm3o6_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  input  wire logic                    start_i,
  input  wire lane_res_t [NumSyms-1:0] lane_i,
  output logic                         push_o,
  output item_t                        item_o
);

  logic            in_packet_q, in_packet_d;
  logic [LenW-1:0] bytes_left_q, bytes_left_d;

  logic             all_ok;
  logic [ByteW-1:0] b0, b1;
  logic [ByteW-1:0] l_minus;
  logic [NibW-1:0]  blocks;
  logic [LenW-1:0]  tel_len, bl;
  logic             active;

  always_comb begin
    all_ok = 1'b1;
    for (int k = 0; k < NumSyms; k++) begin
      all_ok = all_ok & lane_i[k].ok;
    end
    b0 = {lane_i[0].nib, lane_i[1].nib};
    b1 = {lane_i[2].nib, lane_i[3].nib};

    // L + 3 + 2*trunc((L-9)/16), zero block term below 9
    l_minus = b0 - ByteW'(LenBase);
    blocks  = (b0 >= ByteW'(LenBase)) ? l_minus[ByteW-1 -: NibW] : '0;
    tel_len = {1'b0, b0} + LenW'(LenOffset) + {{(LenW-NibW-1){1'b0}}, blocks, 1'b0};

    active = start_i | in_packet_q;
    bl     = start_i ? tel_len : bytes_left_q;

    item_o.byte0 = b0;
    item_o.byte1 = b1;
    item_o.err   = 1'b0;
    item_o.last0 = (bl == LenW'(1));
    item_o.last1 = (bl == LenW'(2));
    item_o.two   = (bl >= LenW'(2));
    push_o       = accept_i & active;

    in_packet_d  = in_packet_q;
    bytes_left_d = bytes_left_q;
    if (accept_i && active) begin
      if (!all_ok) begin
        item_o       = '0;
        item_o.err   = 1'b1;
        in_packet_d  = 1'b0;
        bytes_left_d = '0;
      end else begin
        bytes_left_d = bl - (item_o.two ? LenW'(2) : LenW'(1));
        in_packet_d  = (bytes_left_d != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q  <= 1'b0;
      bytes_left_q <= '0;
    end else begin
      in_packet_q  <= in_packet_d;
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

`default_nettype wire

/* design/wm3o6_out_queue.sv */
// Two-entry result queue; serializes each entry into one or two bytes.
`default_nettype none

module wm3o6_out_queue
  import wm3o6_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  item_t       item_i,
  output logic        room_o,
  wm3o6_byte_if.source out
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            sel_q;
  item_t           head;
  logic            take, pop;

  assign head  = mem_q[rd_q];
  assign take  = out.valid & out.ready;
  assign pop   = take & (sel_q == head.two);
  assign room_o = (cnt_q != CntW'(QueueDepth)) | pop;

  assign out.valid        = (cnt_q != '0);
  assign out.data_byte    = sel_q ? head.byte1 : head.byte0;
  assign out.last_flag    = sel_q ? head.last1 : head.last0;
  assign out.symbol_error = head.err;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      sel_q <= 1'b0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (take) begin
        sel_q <= ~pop;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && cnt_q == CntW'(QueueDepth)) |-> pop)
    else $error("push into full result queue");

  a_sel_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (cnt_q != '0 && head.two))
    else $error("second byte selected without a two-byte entry");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out.valid && head.err) |-> (!head.two && !sel_q))
    else $error("error entry carries more than one result");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("result queue count out of range");

endmodule

`default_nettype wire

/* design/wmbus_three_of_six_telegram_extract_top.sv */
// Top level of the wireless M-Bus mode T 3-out-of-6 telegram extractor.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------
//  grp_i   | in  | valid / ready | code_group[23:0], packet_start
//  byte_o  | out | valid / ready | data_byte[7:0], last_flag, symbol_error
//
// Flow: a group is decoded by four symbol lanes and merged in the cycle it
//   is accepted; its one or two result bytes leave one per cycle, while byte_o
//   is ready, from a two-entry result queue, so the one-byte output port sets
//   the sustained group rate.
// Stalls: groups keep being accepted while earlier results wait, until the
//   queue holds two groups' worth; ignored groups are dropped on acceptance
//   but they too wait for room in the queue.
// Reset: rst_ni clears packet state and the queue; the block is idle after.
`default_nettype none

module wmbus_three_of_six_telegram_extract_top
  import wm3o6_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  wm3o6_grp_if.sink    grp_i,
  wm3o6_byte_if.source byte_o
);

  lane_res_t [NumSyms-1:0] lane_res;
  logic                    accept;
  logic                    push;
  logic                    room;
  item_t                   item;

  assign grp_i.ready = room;
  assign accept      = grp_i.valid & grp_i.ready;

  // Symbol lanes: lane 0 takes the earliest symbol in the top bits.
  for (genvar k = 0; k < NumSyms; k++) begin : g_lane
    wm3o6_sym_lane u_lane (
      .sym_i (grp_i.code_group[GroupW-1-SymW*k -: SymW]),
      .res_o (lane_res[k])
    );
  end

  // Merge: bytes, L field length, remaining count, abort on a bad symbol.
  wm3o6_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .start_i  (grp_i.packet_start),
    .lane_i   (lane_res),
    .push_o   (push),
    .item_o   (item)
  );

  // Result queue and byte serializer.
  wm3o6_out_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .room_o (room),
    .out    (byte_o)
  );

endmodule

`default_nettype wire
